[sv/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, operation codes, word types and saturation for the complex
// arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int W  = 32;           // word bits
	localparam int F  = 16;           // fraction bits
	localparam int PW = 2 * W;        // product width
	localparam int NW = 2 * W + 1;    // sum of two products
	localparam int MW = 2 * W + F + 2; // scaled dividend
	localparam int DW = 2 * W + 1;    // divisor, 2*|b|^2
	localparam int QB = W + 1;        // quotient bits resolved
	localparam int CW = DW + QB;      // divider remainder width
	localparam int SW = 2 * W + 2;    // pre-saturation value width

	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;
	localparam logic [2:0] KIND_CMP = 3'd4;

	typedef struct packed {
		logic [2:0]          kind;
		logic signed [W-1:0] a_re;
		logic signed [W-1:0] a_im;
		logic signed [W-1:0] b_re;
		logic signed [W-1:0] b_im;
	} cmd_t;

	typedef struct packed {
		logic signed [W-1:0] res_re;
		logic signed [W-1:0] res_im;
		logic                both_equal;
		logic                real_less;
		logic                real_greater;
		logic                divide_by_zero;
		logic                saturated;
	} result_t;

	typedef struct packed {
		logic signed [W-1:0] val;
		logic                clip;
	} sat_t;

	function automatic sat_t saturate(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		sat_t r;
		hi = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			r.val  = hi[W-1:0];
			r.clip = 1'b1;
		end else if (v < lo) begin
			r.val  = lo[W-1:0];
			r.clip = 1'b1;
		end else begin
			r.val  = v[W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

[sv/cau_div_lane.sv]
// ----------------------------------------------------------------------------
// cau_div_lane
// Pipelined restoring divider: one quotient bit per stage, with an overflow
// flag when the quotient does not fit in QB bits. Sign travels alongside.
// ----------------------------------------------------------------------------
module cau_div_lane
	import cau_pkg::*;
(
	input  logic          clk,
	input  logic [MW-1:0] m,
	input  logic [DW-1:0] d,
	input  logic          neg,
	output logic [QB-1:0] q,
	output logic          ovf,
	output logic          neg_out
);

	logic [CW-1:0] rem_s [0:QB];
	logic [DW-1:0] d_s   [0:QB];
	logic [QB-1:0] q_s   [0:QB];
	logic          ovf_s [0:QB];
	logic          neg_s [0:QB];

	// entry stage: flag quotients of QB+1 bits or more
	always_ff @(posedge clk) begin
		rem_s[0] <= CW'(m);
		d_s[0]   <= d;
		q_s[0]   <= '0;
		ovf_s[0] <= CW'(m) >= {d, {QB{1'b0}}};
		neg_s[0] <= neg;
	end

	for (genvar i = 0; i < QB; i++) begin : g_stage
		localparam int K = QB - 1 - i;
		logic [CW-1:0] trial;
		logic          ge;
		assign trial = CW'(d_s[i]) << K;
		assign ge    = rem_s[i] >= trial;
		always_ff @(posedge clk) begin
			rem_s[i+1]    <= ge ? rem_s[i] - trial : rem_s[i];
			d_s[i+1]      <= d_s[i];
			q_s[i+1]      <= q_s[i] | (QB'(ge) << K);
			ovf_s[i+1]    <= ovf_s[i];
			neg_s[i+1]    <= neg_s[i];
		end
	end

	assign q       = q_s[QB];
	assign ovf     = ovf_s[QB];
	assign neg_out = neg_s[QB];

endmodule

[sv/complex_arithmetic_unit_core.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex add, subtract, multiply, divide and compare on signed Q16.16.
// Every operation passes stages 1-3, the divider delay and the output register.
// Throughput: one word per cycle; busy is never raised.
// The divide runs as a W+2 stage bit-per-stage pipeline, which sets latency.
// Reset clears the valid bits only; done is low while arst_n is low.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core
	import cau_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output result_t result,
	output logic    done
);

	typedef struct packed {
		logic [2:0]           kind;
		logic signed [W:0]    as_re;
		logic signed [W:0]    as_im;
		logic signed [SW-1:0] mul_re;
		logic signed [SW-1:0] mul_im;
		logic                 dz;
		logic                 eq;
		logic                 lt;
		logic                 gt;
	} ctl_t;

	assign busy = 1'b0;

	// stage 1: products, add/sub, compare
	logic                 v_s1;
	logic [2:0]           kind_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_br_s1, p_bi_s1;
	logic signed [W:0]    as_re_s1, as_im_s1;
	logic                 eq_s1, lt_s1, gt_s1;

	logic signed [PW-1:0] ar, ai, br, bi;
	assign ar = PW'(cmd.a_re);
	assign ai = PW'(cmd.a_im);
	assign br = PW'(cmd.b_re);
	assign bi = PW'(cmd.b_im);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		kind_s1  <= cmd.kind;
		p_rr_s1  <= ar * br;
		p_ii_s1  <= ai * bi;
		p_ri_s1  <= ar * bi;
		p_ir_s1  <= ai * br;
		p_br_s1  <= br * br;
		p_bi_s1  <= bi * bi;
		as_re_s1 <= (cmd.kind == KIND_SUB) ? (W+1)'(cmd.a_re) - (W+1)'(cmd.b_re)
		                                   : (W+1)'(cmd.a_re) + (W+1)'(cmd.b_re);
		as_im_s1 <= (cmd.kind == KIND_SUB) ? (W+1)'(cmd.a_im) - (W+1)'(cmd.b_im)
		                                   : (W+1)'(cmd.a_im) + (W+1)'(cmd.b_im);
		eq_s1    <= (cmd.a_re == cmd.b_re) && (cmd.a_im == cmd.b_im);
		lt_s1    <= cmd.a_re < cmd.b_re;
		gt_s1    <= cmd.a_re > cmd.b_re;
	end

	// stage 2: cross sums, |b|^2
	logic                 v_s2;
	logic [2:0]           kind_s2;
	logic signed [NW-1:0] num_re_s2, num_im_s2;
	logic [PW-1:0]        den_s2;
	logic signed [W:0]    as_re_s2, as_im_s2;
	logic                 eq_s2, lt_s2, gt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		if (kind_s1 == KIND_MUL) begin
			num_re_s2 <= NW'(p_rr_s1) - NW'(p_ii_s1);
			num_im_s2 <= NW'(p_ri_s1) + NW'(p_ir_s1);
		end else begin
			num_re_s2 <= NW'(p_rr_s1) + NW'(p_ii_s1);
			num_im_s2 <= NW'(p_ir_s1) - NW'(p_ri_s1);
		end
		den_s2   <= $unsigned(p_br_s1) + $unsigned(p_bi_s1);
		as_re_s2 <= as_re_s1;
		as_im_s2 <= as_im_s1;
		eq_s2    <= eq_s1;
		lt_s2    <= lt_s1;
		gt_s2    <= gt_s1;
	end

	// stage 3: product rounding, dividend scaling
	logic [NW-1:0] mag_re, mag_im, rnd_re, rnd_im;
	localparam logic [NW-1:0] RND = (F > 0) ? NW'(1) << (F > 0 ? F - 1 : 0) : '0;

	assign mag_re = num_re_s2[NW-1] ? NW'(-num_re_s2) : NW'(num_re_s2);
	assign mag_im = num_im_s2[NW-1] ? NW'(-num_im_s2) : NW'(num_im_s2);
	assign rnd_re = (mag_re + RND) >> F;
	assign rnd_im = (mag_im + RND) >> F;

	logic          v_s3;
	ctl_t          ctl_s3;
	logic [MW-1:0] m_re_s3, m_im_s3;
	logic [DW-1:0] d_s3;
	logic          neg_re_s3, neg_im_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		ctl_s3.kind   <= kind_s2;
		ctl_s3.as_re  <= as_re_s2;
		ctl_s3.as_im  <= as_im_s2;
		ctl_s3.mul_re <= num_re_s2[NW-1] ? -SW'(rnd_re) : SW'(rnd_re);
		ctl_s3.mul_im <= num_im_s2[NW-1] ? -SW'(rnd_im) : SW'(rnd_im);
		ctl_s3.dz     <= den_s2 == '0;
		ctl_s3.eq     <= eq_s2;
		ctl_s3.lt     <= lt_s2;
		ctl_s3.gt     <= gt_s2;
		m_re_s3       <= (MW'(mag_re) << (F + 1)) + MW'(den_s2);
		m_im_s3       <= (MW'(mag_im) << (F + 1)) + MW'(den_s2);
		d_s3          <= {1'b0, den_s2} << 1;
		neg_re_s3     <= num_re_s2[NW-1];
		neg_im_s3     <= num_im_s2[NW-1];
	end

	// divider lanes, control delayed alongside
	logic [QB-1:0] q_re, q_im;
	logic          ovf_re, ovf_im, qneg_re, qneg_im;

	cau_div_lane u_div_re (
		.clk(clk), .m(m_re_s3), .d(d_s3), .neg(neg_re_s3),
		.q(q_re), .ovf(ovf_re), .neg_out(qneg_re)
	);

	cau_div_lane u_div_im (
		.clk(clk), .m(m_im_s3), .d(d_s3), .neg(neg_im_s3),
		.q(q_im), .ovf(ovf_im), .neg_out(qneg_im)
	);

	ctl_t ctl_s [0:QB];
	logic v_s   [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QB; i++) v_s[i] <= 1'b0;
		end else begin
			v_s[0] <= v_s3;
			for (int i = 0; i < QB; i++) v_s[i+1] <= v_s[i];
		end
	end

	always_ff @(posedge clk) begin
		ctl_s[0] <= ctl_s3;
		for (int i = 0; i < QB; i++) ctl_s[i+1] <= ctl_s[i];
	end

	// final select and saturation
	ctl_t                 c;
	logic [SW-1:0]        qm_re, qm_im;
	logic signed [SW-1:0] v_re, v_im;
	sat_t                 s_re, s_im;
	result_t              nxt;

	assign c     = ctl_s[QB];
	// an overflowed quotient only needs to land beyond the word range
	assign qm_re = ovf_re ? SW'(1) << W : SW'(q_re);
	assign qm_im = ovf_im ? SW'(1) << W : SW'(q_im);

	always_comb begin
		v_re = '0;
		v_im = '0;
		case (c.kind)
			KIND_ADD, KIND_SUB: begin
				v_re = SW'(c.as_re);
				v_im = SW'(c.as_im);
			end
			KIND_MUL: begin
				v_re = c.mul_re;
				v_im = c.mul_im;
			end
			KIND_DIV: begin
				v_re = qneg_re ? -$signed(qm_re) : $signed(qm_re);
				v_im = qneg_im ? -$signed(qm_im) : $signed(qm_im);
			end
			default: begin
				v_re = '0;
				v_im = '0;
			end
		endcase
		s_re = saturate(v_re);
		s_im = saturate(v_im);
		nxt  = '0;
		case (c.kind)
			KIND_ADD, KIND_SUB, KIND_MUL: begin
				nxt.res_re    = s_re.val;
				nxt.res_im    = s_im.val;
				nxt.saturated = s_re.clip | s_im.clip;
			end
			KIND_DIV: begin
				if (c.dz) begin
					nxt.divide_by_zero = 1'b1;
				end else begin
					nxt.res_re    = s_re.val;
					nxt.res_im    = s_im.val;
					nxt.saturated = s_re.clip | s_im.clip;
				end
			end
			KIND_CMP: begin
				nxt.both_equal   = c.eq;
				nxt.real_less    = c.lt;
				nxt.real_greater = c.gt;
			end
			default: nxt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= v_s[QB];
	end

	always_ff @(posedge clk) begin
		result <= nxt;
	end

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_by_zero |->
			result.res_re == '0 && result.res_im == '0 && !result.saturated)
		else $error("divide by zero word carries data");

	a_cmp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.real_less && result.real_greater) &&
			!(result.both_equal && (result.real_less || result.real_greater)))
		else $error("compare flags conflict");

	a_flag_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.both_equal || result.real_less || result.real_greater) |->
			!result.saturated && !result.divide_by_zero &&
			result.res_re == '0 && result.res_im == '0)
		else $error("compare word mixed with arithmetic");

endmodule
